/* rtl/aes_pkg.sv */
package aes_pkg;

    localparam int StateWidth = 4;

    localparam logic [StateWidth-1:0] PS_NORMAL  = 4'd0;
    localparam logic [StateWidth-1:0] PS_ESC     = 4'd1;
    localparam logic [StateWidth-1:0] PS_CSI_PAR = 4'd2;
    localparam logic [StateWidth-1:0] PS_CSI_INT = 4'd3;
    localparam logic [StateWidth-1:0] PS_OSC     = 4'd4;
    localparam logic [StateWidth-1:0] PS_OSC_ESC = 4'd5;
    localparam logic [StateWidth-1:0] PS_STR     = 4'd6;
    localparam logic [StateWidth-1:0] PS_STR_ESC = 4'd7;
    localparam logic [StateWidth-1:0] PS_NF      = 4'd8;
    localparam logic [StateWidth-1:0] PS_C1_CSI  = 4'd9;
    localparam logic [StateWidth-1:0] PS_C1_OSC  = 4'd10;

    localparam logic [7:0] CH_BEL  = 8'h07;
    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_LBR  = 8'h5B;
    localparam logic [7:0] CH_RBR  = 8'h5D;
    localparam logic [7:0] CH_DCS  = 8'h50;
    localparam logic [7:0] CH_SOS  = 8'h58;
    localparam logic [7:0] CH_PM   = 8'h5E;
    localparam logic [7:0] CH_APC  = 8'h5F;
    localparam logic [7:0] CH_CSI8 = 8'h9B;
    localparam logic [7:0] CH_ST8  = 8'h9C;
    localparam logic [7:0] CH_OSC8 = 8'h9D;

    typedef struct packed {
        logic [StateWidth-1:0] next_state;
        logic                  keep;
    } step_t;

    function automatic logic is_param(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h3F);
    endfunction

    function automatic logic is_inter(input logic [7:0] c);
        return (c >= 8'h20) && (c <= 8'h2F);
    endfunction

    function automatic logic is_final(input logic [7:0] c);
        return (c >= 8'h40) && (c <= 8'h7E);
    endfunction

    function automatic step_t run_normal(input logic [7:0] c);
        step_t r;
        r.next_state = PS_NORMAL;
        r.keep       = 1'b0;
        if (c == CH_ESC) begin
            r.next_state = PS_ESC;
        end else if (c == CH_CSI8) begin
            r.next_state = PS_C1_CSI;
        end else if (c == CH_OSC8) begin
            r.next_state = PS_C1_OSC;
        end else if (!((c >= 8'h80) && (c <= 8'h9F))) begin
            r.keep = 1'b1;
        end
        return r;
    endfunction

endpackage

/* rtl/ansi_escape_stripper.sv */
// A beat accepted on the slave side goes through the input register, then the output register.
// Throughput: one beat per cycle while m_tready does not hold the output register, set by
// the combinational parser step between the input register and the output register.
// Reset (aresetn low, synchronous) empties both registers and returns the parser
// to the normal text state.
module ansi_escape_stripper
    import aes_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,  // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,  // [7:0] out_byte
    output logic       m_tuser,  // [0] keep
    output logic       m_tlast
);

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_last_reg;
    logic                  out_valid_reg;
    logic [7:0]            out_byte_reg;
    logic                  out_keep_reg;
    logic                  out_last_reg;
    logic [StateWidth-1:0] state_reg;
    logic [StateWidth-1:0] state_next;
    logic                  advance;
    step_t                 step;

    aes_step u_step (
        .state   (state_reg),
        .in_byte (in_byte_reg),
        .result  (step)
    );

    assign advance    = !out_valid_reg || m_tready;
    assign s_tready   = !in_valid_reg || advance;
    assign state_next = in_last_reg ? PS_NORMAL : step.next_state;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= PS_NORMAL;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance && in_valid_reg) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && in_valid_reg) begin
            out_byte_reg <= in_byte_reg;
            out_keep_reg <= step.keep;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_keep_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* rtl/aes_step.sv */
module aes_step
    import aes_pkg::*;
(
    input  logic [StateWidth-1:0] state,
    input  logic [7:0]            in_byte,
    output step_t                 result
);

    step_t norm;
    step_t hold;

    always_comb begin
        norm = run_normal(in_byte);
        hold.next_state = state;
        hold.keep       = 1'b0;
        result.next_state = PS_NORMAL;
        result.keep       = 1'b0;
        unique case (state)
            PS_ESC: begin
                if (in_byte == CH_LBR) begin
                    result.next_state = PS_CSI_PAR;
                end else if (in_byte == CH_RBR) begin
                    result.next_state = PS_OSC;
                end else if (in_byte == CH_DCS || in_byte == CH_SOS ||
                             in_byte == CH_PM  || in_byte == CH_APC) begin
                    result.next_state = PS_STR;
                end else if (is_inter(in_byte)) begin
                    result.next_state = PS_NF;
                end
            end
            PS_CSI_PAR: begin
                if (is_param(in_byte)) begin
                    result = hold;
                end else if (is_inter(in_byte)) begin
                    result.next_state = PS_CSI_INT;
                end else if (!is_final(in_byte)) begin
                    result = norm;
                end
            end
            PS_CSI_INT: begin
                if (is_inter(in_byte)) begin
                    result = hold;
                end else if (!is_final(in_byte)) begin
                    result = norm;
                end
            end
            PS_OSC, PS_OSC_ESC: begin
                if (state == PS_OSC_ESC && in_byte == CH_BSL) begin
                    result.next_state = PS_NORMAL;
                end else if (in_byte == CH_BEL) begin
                    result.next_state = PS_NORMAL;
                end else if (in_byte == CH_ESC) begin
                    result.next_state = PS_OSC_ESC;
                end else begin
                    result.next_state = PS_OSC;
                end
            end
            PS_STR, PS_STR_ESC: begin
                if (state == PS_STR_ESC && in_byte == CH_BSL) begin
                    result.next_state = PS_NORMAL;
                end else if (in_byte == CH_ESC) begin
                    result.next_state = PS_STR_ESC;
                end else begin
                    result.next_state = PS_STR;
                end
            end
            PS_NF: begin
                if (is_inter(in_byte)) begin
                    result = hold;
                end else if (!((in_byte >= 8'h30) && (in_byte <= 8'h7E))) begin
                    result = norm;
                end
            end
            PS_C1_CSI: begin
                if (is_param(in_byte) || is_inter(in_byte)) begin
                    result = hold;
                end else if (!is_final(in_byte)) begin
                    result = norm;
                end
            end
            PS_C1_OSC: begin
                if (in_byte != CH_BEL && in_byte != CH_ST8) begin
                    result = hold;
                end
            end
            default: begin
                result = norm;
            end
        endcase
    end

endmodule

/* tb/sv/testbench.sv */
module testbench;
    import aes_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int RandomItems = 1300;
    localparam int HoldOffCycles = 300;
    localparam int HoldOffAfter = 400;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } text_beat_t;

    class strip_scoreboard;
        typedef struct packed {
            logic [7:0] data;
            logic       keep;
            logic       last;
        } stripped_beat_t;

        stripped_beat_t expected_q[$];
        logic [3:0]     parse_state;
        int             failures;
        int             checked;
        int             kept;
        int             text_ends;

        function new();
            parse_state = PS_NORMAL;
            failures    = 0;
            checked     = 0;
            kept        = 0;
            text_ends   = 0;
        endfunction

        function logic [3:0] plain_step(input logic [7:0] c, output logic keep);
            keep = 1'b0;
            if (c == CH_ESC) return PS_ESC;
            if (c == CH_CSI8) return PS_C1_CSI;
            if (c == CH_OSC8) return PS_C1_OSC;
            if (c[7:5] == 3'b100) return PS_NORMAL;
            keep = 1'b1;
            return PS_NORMAL;
        endfunction

        function logic [3:0] next_parse(input logic [3:0] st, input logic [7:0] c,
                                        output logic keep);
            logic is_int;
            logic is_par;
            logic is_fin;
            is_int = (c[7:4] == 4'h2);
            is_par = (c[7:4] == 4'h3);
            is_fin = (c >= 8'h40) && (c <= 8'h7E);
            keep   = 1'b0;
            case (st)
                PS_ESC: begin
                    if (c == CH_LBR) return PS_CSI_PAR;
                    if (c == CH_RBR) return PS_OSC;
                    if (c == CH_DCS || c == CH_SOS || c == CH_PM || c == CH_APC) return PS_STR;
                    if (is_int) return PS_NF;
                    return PS_NORMAL;
                end
                PS_CSI_PAR: begin
                    if (is_par) return PS_CSI_PAR;
                    if (is_int) return PS_CSI_INT;
                    if (is_fin) return PS_NORMAL;
                    return plain_step(c, keep);
                end
                PS_CSI_INT: begin
                    if (is_int) return PS_CSI_INT;
                    if (is_fin) return PS_NORMAL;
                    return plain_step(c, keep);
                end
                PS_OSC, PS_OSC_ESC: begin
                    if (st == PS_OSC_ESC && c == CH_BSL) return PS_NORMAL;
                    if (c == CH_BEL) return PS_NORMAL;
                    if (c == CH_ESC) return PS_OSC_ESC;
                    return PS_OSC;
                end
                PS_STR, PS_STR_ESC: begin
                    if (st == PS_STR_ESC && c == CH_BSL) return PS_NORMAL;
                    if (c == CH_ESC) return PS_STR_ESC;
                    return PS_STR;
                end
                PS_NF: begin
                    if (is_int) return PS_NF;
                    if (c >= 8'h30 && c <= 8'h7E) return PS_NORMAL;
                    return plain_step(c, keep);
                end
                PS_C1_CSI: begin
                    if (is_par || is_int) return PS_C1_CSI;
                    if (is_fin) return PS_NORMAL;
                    return plain_step(c, keep);
                end
                PS_C1_OSC: begin
                    if (c == CH_BEL || c == CH_ST8) return PS_NORMAL;
                    return PS_C1_OSC;
                end
                default: begin
                    return plain_step(c, keep);
                end
            endcase
        endfunction

        function void note_input(input logic [7:0] data, input logic last);
            stripped_beat_t e;
            logic [3:0]     nxt;
            logic           keep;
            nxt         = next_parse(parse_state, data, keep);
            parse_state = last ? PS_NORMAL : nxt;
            e.data      = data;
            e.keep      = keep;
            e.last      = last;
            expected_q.push_back(e);
            if (keep) kept++;
            if (last) text_ends++;
        endfunction

        function void check_result(input logic [7:0] data, input logic keep,
                                   input logic last);
            stripped_beat_t e;
            checked++;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("Unexpected output beat: data=%02h keep=%b last=%b",
                             data, keep, last);
                end
                return;
            end
            e = expected_q.pop_front();
            if (data !== e.data || keep !== e.keep || last !== e.last) begin
                failures++;
                if (failures <= 10) begin
                    $display("Mismatch on output beat %0d: expected data=%02h keep=%b last=%b, got data=%02h keep=%b last=%b",
                             checked, e.data, e.keep, e.last, data, keep, last);
                end
            end
        endfunction
    endclass

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    strip_scoreboard sb = new();
    text_beat_t      stim_q[$];
    int              cycle_count = 0;
    int              tx_idle_max = 3;

    ansi_escape_stripper u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tuser, m_tlast);
        end
    end

    initial begin
        int  wait_cycles;
        int  rx_idle_max;
        bit  held;
        held = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            rx_idle_max = ((sb.checked / 170) % 3 == 1) ? 0 : 3;
            wait_cycles = $urandom_range(0, rx_idle_max);
            if (!held && sb.checked >= HoldOffAfter) begin
                held        = 1'b1;
                wait_cycles = HoldOffCycles;
            end
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
        end
    end

    task automatic push_fixed(input int v, input logic last);
        text_beat_t t;
        t.data = v[7:0];
        t.last = last;
        stim_q.push_back(t);
    endtask

    task automatic push_byte(input int v);
        push_fixed(v, $urandom_range(0, 59) == 0);
    endtask

    task automatic add_sequence();
        int kind;
        int n;
        int b;
        kind = $urandom_range(0, 11);
        case (kind)
            0, 1: begin
                n = $urandom_range(1, 6);
                repeat (n) push_byte($urandom_range(8'h20, 8'h7E));
            end
            2, 3: begin
                push_byte(CH_ESC);
                push_byte(CH_LBR);
                repeat ($urandom_range(0, 4)) push_byte($urandom_range(8'h30, 8'h3F));
                repeat ($urandom_range(0, 2)) push_byte($urandom_range(8'h20, 8'h2F));
                if ($urandom_range(0, 7) == 0) push_byte($urandom_range(0, 255));
                else push_byte($urandom_range(8'h40, 8'h7E));
            end
            4: begin
                push_byte(CH_ESC);
                push_byte(CH_RBR);
                n = $urandom_range(0, 5);
                repeat (n) begin
                    b = $urandom_range(0, 255);
                    if (b == CH_BEL || b == CH_ESC) b = 8'h41;
                    push_byte(b);
                end
                if ($urandom_range(0, 1) == 0) begin
                    push_byte(CH_BEL);
                end else begin
                    push_byte(CH_ESC);
                    push_byte(CH_BSL);
                end
            end
            5: begin
                push_byte(CH_ESC);
                case ($urandom_range(0, 3))
                    0: push_byte(CH_DCS);
                    1: push_byte(CH_SOS);
                    2: push_byte(CH_PM);
                    default: push_byte(CH_APC);
                endcase
                n = $urandom_range(0, 5);
                repeat (n) begin
                    b = $urandom_range(0, 255);
                    push_byte(b);
                    if (b == CH_ESC) push_byte($urandom_range(8'h60, 8'h7E));
                end
                push_byte(CH_ESC);
                push_byte(CH_BSL);
            end
            6: begin
                push_byte(CH_ESC);
                repeat ($urandom_range(1, 2)) push_byte($urandom_range(8'h20, 8'h2F));
                if ($urandom_range(0, 5) == 0) push_byte($urandom_range(0, 255));
                else push_byte($urandom_range(8'h30, 8'h7E));
            end
            7: begin
                push_byte(CH_ESC);
                push_byte($urandom_range(0, 255));
            end
            8: begin
                push_byte(CH_CSI8);
                repeat ($urandom_range(0, 4)) push_byte($urandom_range(8'h20, 8'h3F));
                if ($urandom_range(0, 5) == 0) push_byte($urandom_range(0, 255));
                else push_byte($urandom_range(8'h40, 8'h7E));
            end
            9: begin
                push_byte(CH_OSC8);
                n = $urandom_range(0, 5);
                repeat (n) begin
                    b = $urandom_range(0, 255);
                    if (b == CH_BEL || b == CH_ST8) b = 8'h5A;
                    push_byte(b);
                end
                if ($urandom_range(0, 1) == 0) push_byte(CH_BEL);
                else push_byte(CH_ST8);
            end
            10: begin
                push_byte($urandom_range(8'h80, 8'h9F));
            end
            default: begin
                n = $urandom_range(1, 4);
                repeat (n) push_byte($urandom_range(0, 255));
            end
        endcase
    endtask

    task automatic send_beat(input text_beat_t t);
        int gap;
        gap = $urandom_range(0, tx_idle_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= t.data;
        s_tlast  <= t.last;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_input(t.data, t.last);
    endtask

    initial begin
        int directed_count;
        int mid_point;

        // Plain text extremes, then a C1 control that is simply dropped.
        push_fixed(8'h41, 1'b0);
        push_fixed(8'h00, 1'b0);
        push_fixed(8'hFF, 1'b0);
        push_fixed(8'h9F, 1'b0);
        // Seven-bit CSI with a parameter, an intermediate and a final byte.
        push_fixed(CH_ESC, 1'b0);
        push_fixed(CH_LBR, 1'b0);
        push_fixed(8'h31, 1'b0);
        push_fixed(8'h20, 1'b0);
        push_fixed(8'h6D, 1'b0);
        // Eight-bit CSI with mixed order, aborted by a line feed that is kept.
        push_fixed(CH_CSI8, 1'b0);
        push_fixed(8'h20, 1'b0);
        push_fixed(8'h31, 1'b0);
        push_fixed(8'h0A, 1'b0);
        // OSC ended by BEL.
        push_fixed(CH_ESC, 1'b0);
        push_fixed(CH_RBR, 1'b0);
        push_fixed(CH_BEL, 1'b0);
        // SOS string with a lone ESC inside, ended by ESC backslash.
        push_fixed(CH_ESC, 1'b0);
        push_fixed(CH_SOS, 1'b0);
        push_fixed(CH_ESC, 1'b0);
        push_fixed(8'h41, 1'b0);
        push_fixed(CH_ESC, 1'b0);
        push_fixed(CH_BSL, 1'b0);
        // Eight-bit OSC ignores ESC backslash and ends on the 8-bit terminator.
        push_fixed(CH_OSC8, 1'b0);
        push_fixed(CH_ESC, 1'b0);
        push_fixed(CH_BSL, 1'b0);
        push_fixed(CH_ST8, 1'b0);
        // An nF escape, then ESC ESC, then a kept byte.
        push_fixed(CH_ESC, 1'b0);
        push_fixed(8'h28, 1'b0);
        push_fixed(8'h42, 1'b0);
        push_fixed(CH_ESC, 1'b0);
        push_fixed(CH_ESC, 1'b0);
        push_fixed(8'h63, 1'b0);
        // End of text inside an open OSC returns the parser to normal.
        push_fixed(CH_ESC, 1'b0);
        push_fixed(CH_RBR, 1'b0);
        push_fixed(8'h41, 1'b1);
        directed_count = stim_q.size();

        while (stim_q.size() < directed_count + RandomItems) add_sequence();
        mid_point = directed_count + (stim_q.size() - directed_count) / 2;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < stim_q.size(); i++) begin
            if (i == directed_count || i == mid_point) begin
                s_tvalid <= 1'b0;
                while (sb.expected_q.size() != 0) @(posedge aclk);
                @(posedge aclk);
            end
            tx_idle_max = ((i / 150) % 3 == 0) ? 0 : 3;
            send_beat(stim_q[i]);
        end
        s_tvalid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Streamed %0d text bytes through CSI, OSC, string, nF and C1 sequences.",
                 stim_q.size());
        $display("Output beats checked: %0d, kept: %0d, ends of text: %0d, failures: %0d.",
                 sb.checked, sb.kept, sb.text_ends, sb.failures);
        if (sb.failures == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
